### hdl/box_downsample_4x4_macros.svh
// Assertion macros for the 4x4 box downsampler checker.
// Used by bds_checker.sv; needs a clock and an active-low reset name at each use.
`ifndef BOX_DOWNSAMPLE_4X4_MACROS_SVH
`define BOX_DOWNSAMPLE_4X4_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bds checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bds checker: next-cycle property failed");

`endif

### hdl/bds_pkg.sv
// Shared types and constants of the 4x4 box downsampler.
// No dependencies; imported by the interfaces, bds_front, bds_colsum and the top level.
`default_nettype none

package bds_pkg;

    localparam int NUM_CH         = 4;   // red, green, blue, alpha
    localparam int CH_W           = 8;
    localparam int HS_W           = 10;  // sum of four pixels of one row
    localparam int CS_W           = 12;  // sum of sixteen pixels
    localparam int AVG_SHIFT      = 4;   // divide by sixteen
    localparam int OUT_COLS_W     = 10;
    localparam logic [OUT_COLS_W-1:0] OUT_COLS_RESET = 10'd40;
    localparam logic [1:0] GRP_FIRST  = 2'd0;
    localparam logic [1:0] GRP_LAST   = 2'd3;
    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef logic [NUM_CH-1:0][CH_W-1:0] chan_t;
    typedef logic [NUM_CH-1:0][HS_W-1:0] hsum_t;
    typedef logic [NUM_CH-1:0][CS_W-1:0] csum_t;

    // Position flags of the pixel currently offered, after frame start.
    typedef struct packed {
        logic grp_start;  // first pixel of a four-pixel group
        logic grp_end;    // last pixel of a four-pixel group
        logic first_row;  // first input row of a block row
        logic last_row;   // last input row of a block row
        logic row_last;   // pixel ends the input row
        logic may_emit;   // stored position could produce a result
    } pos_flags_t;

endpackage

`default_nettype wire

### hdl/bds_pix_if.sv
// Input pixel channel: valid/ready handshake plus one RGBA pixel and frame start.
// Depends on bds_pkg.
`default_nettype none

interface bds_pix_if
    import bds_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            frame_start;

    modport source (output valid, red, green, blue, alpha, frame_start, input ready);
    modport sink   (input valid, red, green, blue, alpha, frame_start, output ready);
endinterface

`default_nettype wire

### hdl/bds_avg_if.sv
// Output channel: valid/ready handshake plus one averaged RGBA pixel and row end.
// Depends on bds_pkg.
`default_nettype none

interface bds_avg_if
    import bds_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_avg;
    logic [CH_W-1:0] green_avg;
    logic [CH_W-1:0] blue_avg;
    logic [CH_W-1:0] alpha_avg;
    logic            row_end;

    modport source (output valid, red_avg, green_avg, blue_avg, alpha_avg, row_end,
                    input ready);
    modport sink   (input valid, red_avg, green_avg, blue_avg, alpha_avg, row_end,
                    output ready);
endinterface

`default_nettype wire

### hdl/bds_front.sv
// Position counters and horizontal four-pixel sums of the downsampler.
// Depends on bds_pkg.
`default_nettype none

module bds_front
    import bds_pkg::*;
#(
    parameter  int MAX_OUT_COLS = 512,
    localparam int IDX_W        = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    acc,
    input  wire logic                    frame_start,
    input  wire chan_t                   px,
    input  wire logic [OUT_COLS_W-1:0]   out_cols,
    output pos_flags_t                   flags,
    output logic [IDX_W-1:0]             idx,
    output hsum_t                        hs
);

    localparam int COL_W = IDX_W + 2;
    localparam int CNT_W = (IDX_W + 1 > OUT_COLS_W) ? IDX_W + 1 : OUT_COLS_W;
    localparam int LST_W = CNT_W + 2;

    logic [COL_W-1:0] col_reg, col_next, col_eff;
    logic [1:0]       phase_reg, phase_next, phase_eff;
    hsum_t            hs_reg;
    logic [CNT_W-1:0] cfg_ext, cols_eff;
    logic [LST_W-1:0] last_col;

    // Clamp width to 1..MAX_OUT_COLS.
    always_comb
    begin
        cfg_ext = CNT_W'(out_cols);
        if (out_cols == '0)
            cols_eff = CNT_W'(1);
        else if (cfg_ext > CNT_W'(MAX_OUT_COLS))
            cols_eff = CNT_W'(MAX_OUT_COLS);
        else
            cols_eff = cfg_ext;
        last_col = {cols_eff, 2'b00} - LST_W'(1);
    end

    assign col_eff   = frame_start ? '0 : col_reg;
    assign phase_eff = frame_start ? '0 : phase_reg;

    always_comb
    begin
        flags.grp_start = (col_eff[1:0] == GRP_FIRST);
        flags.grp_end   = (col_eff[1:0] == GRP_LAST);
        flags.first_row = (phase_eff == '0);
        flags.last_row  = (phase_eff == PHASE_LAST);
        flags.row_last  = (LST_W'(col_eff) >= last_col);
        flags.may_emit  = (col_reg[1:0] == GRP_LAST) && (phase_reg == PHASE_LAST);
        for (int k = 0; k < NUM_CH; k++)
        begin
            hs[k] = flags.grp_start ? HS_W'(px[k]) : hs_reg[k] + HS_W'(px[k]);
        end
    end

    assign idx = col_eff[COL_W-1:2];

    // Wrap at row end and advance row phase.
    always_comb
    begin
        if (flags.row_last)
        begin
            col_next   = '0;
            phase_next = phase_eff + 2'd1;
        end
        else
        begin
            col_next   = col_eff + COL_W'(1);
            phase_next = phase_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            phase_reg <= '0;
        end
        else if (acc)
        begin
            col_reg   <= col_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            hs_reg <= hs;
    end

endmodule

`default_nettype wire

### hdl/bds_colsum.sv
// Column-sum line store with read-modify-write of the four channel lanes.
// Depends on bds_pkg.
`default_nettype none

module bds_colsum
    import bds_pkg::*;
#(
    parameter  int MAX_OUT_COLS = 512,
    localparam int IDX_W        = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             acc,
    input  wire pos_flags_t       flags,
    input  wire logic [IDX_W-1:0] idx,
    input  wire hsum_t            hs,
    output csum_t                 cs
);

    csum_t colsum_mem [MAX_OUT_COLS];
    csum_t rd_data_reg;

    // Read at the group's first pixel, write back at its last; the group
    // spans four accepted pixels, so the read data is registered in time.
    always_ff @(posedge clk)
    begin
        if (acc && flags.grp_start)
            rd_data_reg <= colsum_mem[idx];
        if (acc && flags.grp_end)
            colsum_mem[idx] <= cs;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            cs[k] = flags.first_row ? CS_W'(hs[k]) : rd_data_reg[k] + CS_W'(hs[k]);
        end
    end

endmodule

`default_nettype wire

### hdl/box_downsample_4x4.sv
// Top level of the 4x4 RGBA box-filter downsampler.
// Depends on bds_pkg, bds_pix_if, bds_avg_if, bds_front and bds_colsum.
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  ---------------------------------------------
//  pix_in    in   valid / ready    red, green, blue, alpha (8b), frame_start
//  avg_out   out  valid / ready    red_avg, green_avg, blue_avg, alpha_avg, row_end
//  cfg       in   cfg_wr_en        cfg_wr_data: out_cols (10b), reset 40
//
//  One pixel per clock is accepted while ready is high; a result is valid in
//  the cycle after the pixel that completes its block. The line store is read at
//  the first pixel of each four-pixel group and written at its last, so one port
//  pair covers it. Reset clears the position counters and output valid and sets
//  the width to 40; the line store is not cleared. Input stalls only when the next
//  pixel could complete a block while the output register holds an untaken result.
`default_nettype none

module box_downsample_4x4
    import bds_pkg::*;
#(
    parameter int MAX_OUT_COLS = 512
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [OUT_COLS_W-1:0] cfg_wr_data,
    bds_pix_if.sink                    pix_in,
    bds_avg_if.source                  avg_out
);

    localparam int IDX_W = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;

    logic [OUT_COLS_W-1:0] out_cols_reg;
    pos_flags_t            flags;
    logic [IDX_W-1:0]      idx;
    hsum_t                 hs;
    csum_t                 cs;
    chan_t                 px;
    logic                  acc;
    logic                  emit;
    logic                  out_valid_reg, out_valid_next;
    chan_t                 avg_reg;
    logic                  row_end_reg;

    assign px = {pix_in.alpha, pix_in.blue, pix_in.green, pix_in.red};

    // Hold input only when a result could land on a full, stalled output.
    assign pix_in.ready = !(flags.may_emit && out_valid_reg && !avg_out.ready);
    assign acc          = pix_in.valid && pix_in.ready;
    assign emit         = acc && flags.grp_end && flags.last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_cols_reg <= OUT_COLS_RESET;
        else if (cfg_wr_en)
            out_cols_reg <= cfg_wr_data;
    end

    bds_front #(
        .MAX_OUT_COLS (MAX_OUT_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .frame_start (pix_in.frame_start),
        .px          (px),
        .out_cols    (out_cols_reg),
        .flags       (flags),
        .idx         (idx),
        .hs          (hs)
    );

    bds_colsum #(
        .MAX_OUT_COLS (MAX_OUT_COLS)
    ) u_colsum (
        .clk   (clk),
        .acc   (acc),
        .flags (flags),
        .idx   (idx),
        .hs    (hs),
        .cs    (cs)
    );

    // Load a new result, drop one taken downstream, otherwise hold.
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (avg_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Block sum over sixteen, rounded down.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int k = 0; k < NUM_CH; k++)
            begin
                avg_reg[k] <= cs[k][CS_W-1:AVG_SHIFT];
            end
            row_end_reg <= flags.row_last;
        end
    end

    assign avg_out.valid     = out_valid_reg;
    assign avg_out.red_avg   = avg_reg[0];
    assign avg_out.green_avg = avg_reg[1];
    assign avg_out.blue_avg  = avg_reg[2];
    assign avg_out.alpha_avg = avg_reg[3];
    assign avg_out.row_end   = row_end_reg;

endmodule

`default_nettype wire

### hdl/bds_checker.sv
// Port-level checker for box_downsample_4x4, bound to the top level.
// Depends on box_downsample_4x4_macros.svh.
`default_nettype none
`include "box_downsample_4x4_macros.svh"

module bds_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_frame_start,
    input wire logic out_valid,
    input wire logic out_ready
);

    // Hold a result until it is taken.
    `BDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // Input stalls only behind a stalled result.
    `BDS_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)
    // A new result follows an input transaction.
    `BDS_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))
    // The first pixel of a frame completes no block.
    `BDS_ASSERT_NEXT(a_frame_start, clk, rst_n, in_valid && in_ready && in_frame_start, !$rose(out_valid))

endmodule

bind box_downsample_4x4 bds_checker u_bds_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pix_in.valid),
    .in_ready       (pix_in.ready),
    .in_frame_start (pix_in.frame_start),
    .out_valid      (avg_out.valid),
    .out_ready      (avg_out.ready)
);

`default_nettype wire

### sim/bds_avg_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 4x4 box downsampler: watches the pixel, average and width ports,
// predicts every averaged pixel and compares it. Needs bds_pkg, bds_pix_if, bds_avg_if.

module bds_avg_checker
    import bds_pkg::*;
#(
    parameter int MAX_OUT_COLS = 512
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [OUT_COLS_W-1:0] cfg_wr_data,
    bds_pix_if                         pix,
    bds_avg_if                         avg,
    output int                         pending,
    output int                         fail_count
);

    localparam logic [1:0] PHASE_FIRST = 2'd0;

    typedef struct packed {
        chan_t lanes;
        logic  row_end;
    } avg_pixel_t;

    avg_pixel_t            avg_expect_q [$];
    logic [OUT_COLS_W-1:0] out_cols;
    csum_t                 col_sums [MAX_OUT_COLS];
    hsum_t                 group_sum;
    logic [10:0]           in_col;
    logic [1:0]            row_phase;
    string                 lane_names [NUM_CH];

    initial
    begin
        lane_names = '{"red_avg", "green_avg", "blue_avg", "alpha_avg"};
    end

    // Add one input pixel into the running sums; queue an average when a block closes.
    task automatic accumulate_pixel(input chan_t px, input logic fs);
        int         cols;
        int         last_col;
        int         slot;
        avg_pixel_t res;
        cols = (out_cols == '0) ? 1 : int'(out_cols);
        if (cols > MAX_OUT_COLS)
            cols = MAX_OUT_COLS;
        last_col = 4 * cols - 1;
        if (fs)
        begin
            in_col    = '0;
            row_phase = PHASE_FIRST;
        end
        for (int k = 0; k < NUM_CH; k++)
            group_sum[k] = ((in_col[1:0] == GRP_FIRST) ? '0 : group_sum[k]) + HS_W'(px[k]);
        if (in_col[1:0] == GRP_LAST)
        begin
            slot = (in_col >> 2) % MAX_OUT_COLS;
            for (int k = 0; k < NUM_CH; k++)
                col_sums[slot][k] = ((row_phase == PHASE_FIRST) ? '0 : col_sums[slot][k])
                                    + CS_W'(group_sum[k]);
            if (row_phase == PHASE_LAST)
            begin
                for (int k = 0; k < NUM_CH; k++)
                    res.lanes[k] = col_sums[slot][k][CS_W-1:AVG_SHIFT];
                res.row_end = (in_col >= last_col);
                avg_expect_q = {avg_expect_q, res};
            end
        end
        if (in_col >= last_col)
        begin
            in_col    = '0;
            row_phase = row_phase + 1'b1;
        end
        else
            in_col = in_col + 1'b1;
    endtask

    task automatic compare_avg(input avg_pixel_t got);
        avg_pixel_t want;
        if (avg_expect_q.size() == 0)
        begin
            $display("%0t: unexpected average %h row_end %0b", $time, got.lanes, got.row_end);
            fail_count++;
            return;
        end
        want = avg_expect_q.pop_front();
        for (int k = 0; k < NUM_CH; k++)
            if (got.lanes[k] !== want.lanes[k])
            begin
                $display("%0t: %s expected %0d, got %0d", $time, lane_names[k],
                         want.lanes[k], got.lanes[k]);
                fail_count++;
            end
        if (got.row_end !== want.row_end)
        begin
            $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, got.row_end);
            fail_count++;
        end
    endtask

    // Predict before compare so a same-edge result would still find its expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cols  = OUT_COLS_RESET;
            group_sum = '0;
            in_col    = '0;
            row_phase = PHASE_FIRST;
            foreach (col_sums[i])
                col_sums[i] = '0;
            avg_expect_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                out_cols = cfg_wr_data;
            if (pix.valid && pix.ready)
                accumulate_pixel({pix.alpha, pix.blue, pix.green, pix.red}, pix.frame_start);
            if (avg.valid && avg.ready)
                compare_avg({avg.alpha_avg, avg.blue_avg, avg.green_avg, avg.red_avg,
                             avg.row_end});
        end
        pending = avg_expect_q.size();
    end

endmodule

### sim/tb_box_downsample_4x4.sv
`timescale 1ns / 100ps
// Testbench top for the 4x4 box downsampler: drives pixels, width writes and output
// stalls, and gives the verdict. Needs bds_pkg, both channel interfaces and bds_avg_checker.

module tb_box_downsample_4x4;
    import bds_pkg::*;

    localparam int MAX_COLS     = 512;
    localparam int RANDOM_ITEMS = 1260;  // pixels of the random phases
    localparam int DRAIN_CYCLES = 4;    // result shows in the cycle after its closing pixel
    localparam int TAIL_CYCLES  = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [OUT_COLS_W-1:0] cfg_wr_data;
    int                    pending;
    int                    fail_count;
    int                    cur_cols;    // effective width the block works with now
    bit                    no_gaps;     // hold valid high back to back

    bds_pix_if pix ();
    bds_avg_if avg ();

    box_downsample_4x4 #(.MAX_OUT_COLS(MAX_COLS)) u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix_in      (pix),
        .avg_out     (avg)
    );

    bds_avg_checker #(.MAX_OUT_COLS(MAX_COLS)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix         (pix),
        .avg         (avg),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Widths of 0 behave as 1, anything above the line store size as its size.
    function automatic int eff_cols(input int w);
        return (w == 0) ? 1 : ((w > MAX_COLS) ? MAX_COLS : w);
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(20, 8);
    endfunction

    // Random pixel, with a lane forced to zero or full scale now and then.
    function automatic chan_t rand_pixel();
        chan_t px;
        px = $urandom;
        for (int k = 0; k < NUM_CH; k++)
            case ($urandom_range(15))
                0:       px[k] = '0;
                1:       px[k] = '1;
                default: ;
            endcase
        return px;
    endfunction

    // Offer one pixel at the falling edge and hold it until the transaction completes.
    // Entered and left at a falling edge.
    task automatic send_pixel(input chan_t px, input logic fs);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid       <= 1'b1;
        pix.red         <= px[0];
        pix.green       <= px[1];
        pix.blue        <= px[2];
        pix.alpha       <= px[3];
        pix.frame_start <= fs;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random pixels; the first may open a frame, a noisy run scatters frame starts.
    task automatic send_run(input int count, input bit fs_first, input bit noisy);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(),
                       (i == 0 && fs_first) || (noisy && $urandom_range(15) == 0));
    endtask

    // Drop valid, let every pending average drain plus DRAIN_CYCLES more for a block that
    // may still be busy on a pixel that closes nothing, then write the width.
    task automatic set_width(input logic [OUT_COLS_W-1:0] w);
        pix.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_cols = eff_cols(int'(w));
    endtask

    // Output side: random stalls of varied length, and long stretches always ready.
    initial
    begin
        int hold;
        avg.ready = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if ($urandom_range(9) == 0)
            begin
                avg.ready <= 1'b1;
                hold = $urandom_range(200, 50);
            end
            else
            begin
                avg.ready <= ($urandom_range(2) != 0);
                hold = pick_gap();
            end
        end
    end

    initial
    begin
        chan_t px;
        int    w;
        int    n;
        int    random_sent;
        bit    fs_first;
        bit    noisy;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        pix.valid       = 1'b0;
        pix.red         = '0;
        pix.green       = '0;
        pix.blue        = '0;
        pix.alpha       = '0;
        pix.frame_start = 1'b0;
        no_gaps         = 1'b0;
        cur_cols        = eff_cols(int'(OUT_COLS_RESET));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Width zero acts as one: each 16 pixels make one output row of one pixel.
        // Full-scale block first, so the sums reach their top value.
        set_width('0);
        for (int i = 0; i < 16; i++)
            send_pixel('1, i == 0);

        // Floors: red ramps 0..15 (mean 7.5), green mirrors it, blue sums to 15
        // (rounds down to 0), alpha sums to exactly 16.
        for (int i = 0; i < 16; i++)
        begin
            px[0] = i[7:0];
            px[1] = 8'd255 - i[7:0];
            px[2] = (i == 15) ? 8'd15 : 8'd0;
            px[3] = (i == 0) ? 8'd16 : 8'd0;
            send_pixel(px, 1'b0);
        end

        // All-zero block at an explicit width of one, in a fresh frame.
        set_width(10'd1);
        for (int i = 0; i < 16; i++)
            send_pixel('0, i == 0);

        // Width above the store size clamps to it: part of a row there in a fresh frame,
        // then narrow the width mid-row so the next pixel ends the row at once; finish
        // the block row at the new width.
        set_width('1);
        send_run(300, 1'b1, 1'b0);
        set_width(10'd20);
        send_run(1 + 3 * 4 * 20, 1'b0, 1'b0);

        // Random phases: new width each time, mostly whole block rows with random
        // content, sometimes a partial tail or a short noisy run with stray frame starts.
        // A wider width always opens a new frame, so no stale line store entry is read.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            n = $urandom_range(99);
            if (n < 5)
                w = 0;
            else if (n < 45)
                w = $urandom_range(4, 1);
            else if (n < 80)
                w = $urandom_range(16, 5);
            else if (n < 95)
                w = $urandom_range(64, 17);
            else
                w = $urandom_range(128, 65);
            fs_first = (eff_cols(w) > cur_cols) || ($urandom_range(1) == 0);
            set_width(OUT_COLS_W'(w));
            no_gaps = ($urandom_range(3) == 0);
            noisy   = 1'b0;
            if ($urandom_range(3) != 0)
            begin
                n = $urandom_range(3, 1) * 16 * cur_cols;
                if ($urandom_range(2) == 0)
                    n += $urandom_range(16 * cur_cols - 1);
            end
            else
            begin
                n     = $urandom_range(64, 1);
                noisy = 1'b1;
            end
            // Cut the last run to the remaining budget.
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            send_run(n, fs_first, noisy);
            random_sent += n;
        end

        // Drain, then wait TAIL_CYCLES more for anything that should not come.
        pix.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending != 0)
            $display("%0t: %0d averaged pixels never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
